>>> hw/rtl/b64d_pkg.sv
package b64d_pkg;

  localparam int CharW  = 8;
  localparam int SextW  = 6;
  localparam int CountW = 3;
  localparam int ByteW  = 8;

  // Character codes with a special meaning in the stream.
  localparam logic [CharW-1:0] ChEquals = 8'h3D;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChSlash  = 8'h2F;
  localparam logic [CharW-1:0] ChUscore = 8'h5F;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
  localparam logic [CharW-1:0] ChDigit0 = 8'h30;
  localparam logic [CharW-1:0] ChDigit9 = 8'h39;

  localparam logic [SextW-1:0] LowerBase = 6'd26;
  localparam logic [SextW-1:0] DigitBase = 6'd52;
  localparam logic [SextW-1:0] SextPlus  = 6'd62;
  localparam logic [SextW-1:0] SextSlash = 6'd63;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_TERM = 2'd1,
    KIND_DATA = 2'd2
  } char_kind_t;

  typedef struct packed {
    char_kind_t       kind;
    logic [SextW-1:0] sextet;
  } char_class_t;

endpackage

>>> hw/rtl/b64d_char_class.sv
module b64d_char_class
  import b64d_pkg::*;
(
  input  logic [CharW-1:0] char_code,
  output char_class_t      cls
);

  logic [CharW-1:0] off_upper;
  logic [CharW-1:0] off_lower;
  logic [CharW-1:0] off_digit;

  assign off_upper = char_code - ChUpperA;
  assign off_lower = char_code - ChLowerA;
  assign off_digit = char_code - ChDigit0;

  // Both the standard and the URL-safe alphabet map onto the same values.
  always_comb begin
    cls.kind   = KIND_SKIP;
    cls.sextet = '0;
    if (char_code == ChEquals || char_code == ChCr || char_code == ChLf) begin
      cls.kind = KIND_TERM;
    end else if (char_code >= ChUpperA && char_code <= ChUpperZ) begin
      cls.kind   = KIND_DATA;
      cls.sextet = off_upper[SextW-1:0];
    end else if (char_code >= ChLowerA && char_code <= ChLowerZ) begin
      cls.kind   = KIND_DATA;
      cls.sextet = LowerBase + off_lower[SextW-1:0];
    end else if (char_code >= ChDigit0 && char_code <= ChDigit9) begin
      cls.kind   = KIND_DATA;
      cls.sextet = DigitBase + off_digit[SextW-1:0];
    end else if (char_code == ChPlus || char_code == ChMinus) begin
      cls.kind   = KIND_DATA;
      cls.sextet = SextPlus;
    end else if (char_code == ChSlash || char_code == ChUscore) begin
      cls.kind   = KIND_DATA;
      cls.sextet = SextSlash;
    end
  end

endmodule

>>> hw/rtl/b64d_bit_packer.sv
module b64d_bit_packer
  import b64d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             string_start,
  input  char_class_t      cls,
  output logic             byte_valid,
  output logic [ByteW-1:0] byte_data
);

  logic [SextW-1:0]    bits_r,    bits_nxt;
  logic [CountW-1:0]   count_r,   count_nxt;
  logic                stopped_r, stopped_nxt;

  logic [SextW-1:0]    bits_cur;
  logic [CountW-1:0]   count_cur;
  logic                stopped_cur;
  logic [2*SextW-1:0]  acc;
  logic [CountW-1:0]   count_left;
  logic [SextW-1:0]    keep_mask;
  logic [2*SextW-1:0]  acc_shift;

  // A new string clears the state before its first character is handled.
  assign bits_cur    = string_start ? '0 : bits_r;
  assign count_cur   = string_start ? '0 : count_r;
  assign stopped_cur = string_start ? 1'b0 : stopped_r;

  assign acc        = {bits_cur, cls.sextet};
  assign count_left = count_cur - CountW'(2);
  assign acc_shift  = acc >> count_left;
  assign keep_mask  = SextW'((7'd1 << count_left) - 7'd1);

  always_comb begin
    bits_nxt    = bits_cur;
    count_nxt   = count_cur;
    stopped_nxt = stopped_cur;
    byte_valid  = 1'b0;
    byte_data   = acc_shift[ByteW-1:0];
    if (!stopped_cur) begin
      unique case (cls.kind)
        KIND_TERM: stopped_nxt = 1'b1;
        KIND_DATA: begin
          if (count_cur == '0) begin
            bits_nxt  = cls.sextet;
            count_nxt = CountW'(SextW);
          end else begin
            byte_valid = 1'b1;
            bits_nxt   = acc[SextW-1:0] & keep_mask;
            count_nxt  = count_left;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r    <= '0;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else if (step) begin
      bits_r    <= bits_nxt;
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

>>> hw/rtl/base64_stream_decoder_core.sv
// Base64 stream decoder. One character enters per in_ transaction and at
// most one decoded byte leaves per out_ transaction. Standard and URL-safe
// alphabets are both accepted; characters outside them are skipped, and an
// equals sign, CR or LF ends the string so that later characters are ignored
// until one arrives with in_tuser high, which clears the decoder state before
// that character is handled. Leftover bits at the end of a string are
// dropped. The block sustains one character per clock while out_tready
// keeps the output drained: a character is captured in an input register
// and, once the output register is free, decoded into the output register,
// which drives out_tvalid and out_tdata. Throughput is limited only by
// backpressure on out_tready.
module base64_stream_decoder_core
  import b64d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [CharW-1:0] in_tdata,   // [7:0] char_code
  input  logic             in_tuser,   // [0] string_start

  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ByteW-1:0] out_tdata   // [7:0] data_byte
);

  logic             s1_valid_r;
  logic [CharW-1:0] s1_char_r;
  logic             s1_start_r;

  logic             out_valid_r;
  logic [ByteW-1:0] out_data_r;

  logic             out_free;
  logic             step;
  char_class_t      cls;
  logic             byte_valid;
  logic [ByteW-1:0] byte_data;

  // The output register can take a new result when it is empty or is being
  // drained in this cycle; the input register then moves on as well.
  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  b64d_char_class u_char_class (
    .char_code (s1_char_r),
    .cls       (cls)
  );

  // Holds the pending bits, their count and the stopped flag.
  b64d_bit_packer u_bit_packer (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .string_start (s1_start_r),
    .cls          (cls),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && byte_valid) begin
      out_data_r <= byte_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> dv/base64_stream_decoder_core_test.sv
// Self-checking testbench for the base64 stream decoder.
//
// Characters go into the decoder over the in_ stream, one per transaction.
// Every accepted character is also fed to a predictor in this module, which
// keeps its own copy of the pending bits, the bit count and the stopped flag.
// When the predictor says that a character completes a byte, the byte is
// queued. Each out_ transaction is then compared against the oldest byte in
// that queue.
//
// The stimulus is split into named tests that run one after another:
//   - a short directed string that touches both alphabets, the terminators,
//     foreign bytes and restarts;
//   - random well-formed strings, with some noise and broken strings mixed in;
//   - a long hold on out_tready while characters keep arriving, so the decoder
//     fills up and must stall its input;
//   - a final stretch at full rate, with no idle cycles on either side.
module base64_stream_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  // A transaction happens at least this often unless the decoder has hung.
  // The pressure hold is the longest stretch without one.
  localparam int IdleLimit     = 3000;
  localparam int PressureHold  = 300;
  localparam int RandomItems   = 1100;
  localparam int FullRateItems = 300;
  // The decoder has two register stages, so the DrainCycles wait after the
  // last byte is enough to see any stray output.
  localparam int DrainCycles   = 10;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [CharW-1:0] in_tdata   = '0;    // [7:0] char_code
  logic             in_tuser   = 1'b0;  // [0] string_start
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [ByteW-1:0] out_tdata;          // [7:0] data_byte

  base64_stream_decoder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state. It mirrors what the decoder should hold between
  // characters: the leftover bits, right-aligned, and how many of them count.
  logic [SextW-1:0]  pend_bits = '0;
  logic [CountW-1:0] pend_cnt  = '0;
  bit                halted    = 1'b0;

  logic [ByteW-1:0] expected_bytes[$];
  logic [ByteW-1:0] predicted_byte;
  logic [ByteW-1:0] oldest_byte;

  int  mismatches = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  tx_idle_en = 1'b0;
  bit  rx_idle_en = 1'b0;

  // The pressure test raises hold_seq to ask the receiver for a long hold of
  // length hold_len; the receiver counts the hold down on its own.
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_len = 0;
  int  stall_left = 0;

  // Sorts a character into skip, terminator or data, and gives its six-bit
  // value for data characters.
  function automatic char_kind_t classify_char(input logic [CharW-1:0] ch,
                                               output logic [SextW-1:0] sextet);
    sextet = '0;
    if (ch == ChEquals || ch == ChCr || ch == ChLf) return KIND_TERM;
    if (ch >= ChUpperA && ch <= ChUpperZ) begin
      sextet = SextW'(ch - ChUpperA);
      return KIND_DATA;
    end
    if (ch >= ChLowerA && ch <= ChLowerZ) begin
      sextet = LowerBase + SextW'(ch - ChLowerA);
      return KIND_DATA;
    end
    if (ch >= ChDigit0 && ch <= ChDigit9) begin
      sextet = DigitBase + SextW'(ch - ChDigit0);
      return KIND_DATA;
    end
    if (ch == ChPlus || ch == ChMinus) begin
      sextet = SextPlus;
      return KIND_DATA;
    end
    if (ch == ChSlash || ch == ChUscore) begin
      sextet = SextSlash;
      return KIND_DATA;
    end
    return KIND_SKIP;
  endfunction

  // Advances the predictor by one accepted character. Returns 1 when the
  // character completes a byte, which is then given in data_out.
  function automatic bit decode_char(input logic [CharW-1:0] ch, input logic start,
                                     output logic [ByteW-1:0] data_out);
    logic [SextW-1:0]   sextet;
    logic [2*SextW-1:0] acc;
    int unsigned        width;
    char_kind_t         kind;
    data_out = '0;
    // A new string throws away whatever the previous one left behind,
    // including a stop, before this character is looked at.
    if (start) begin
      pend_bits = '0;
      pend_cnt  = '0;
      halted    = 1'b0;
    end
    if (halted) return 1'b0;
    kind = classify_char(ch, sextet);
    if (kind == KIND_TERM) begin
      halted = 1'b1;
      return 1'b0;
    end
    if (kind == KIND_SKIP) return 1'b0;
    acc   = {pend_bits, sextet};
    width = pend_cnt + 6;
    if (width < 8) begin
      pend_bits = sextet;
      pend_cnt  = CountW'(width);
      return 1'b0;
    end
    // The byte is the top eight of the gathered bits; the rest stay pending.
    data_out  = ByteW'(acc >> (width - 8));
    width     = width - 8;
    pend_bits = SextW'(acc & ((12'd1 << width) - 12'd1));
    pend_cnt  = CountW'(width);
    return 1'b1;
  endfunction

  // Turns a six-bit value back into a character, choosing either alphabet at
  // random for the two values where they differ.
  function automatic logic [CharW-1:0] char_of_sextet(input int unsigned v);
    if (v < 26) return ChUpperA + CharW'(v);
    if (v < 52) return ChLowerA + CharW'(v - 26);
    if (v < 62) return ChDigit0 + CharW'(v - 52);
    if (v == 62) return ($urandom_range(0, 1) != 0) ? ChPlus : ChMinus;
    return ($urandom_range(0, 1) != 0) ? ChSlash : ChUscore;
  endfunction

  // Offers one character and returns at the edge where the transaction
  // happens. An idle burst may come first while sender idling is on.
  task automatic send_char(input logic [CharW-1:0] ch, input logic start);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Sends one string of len data characters, opened by a start flag, with
  // a little noise inside, an optional ending and up to three random tail bytes.
  // A broken string lets terminators and restarts fall anywhere.
  task automatic send_string(input int len, input bit broken);
    logic [CharW-1:0] noise;
    send_char(char_of_sextet($urandom_range(0, 63)), 1'b1);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        noise = CharW'($urandom_range(0, 255));
        // Inside a well-formed string, noise must not end the string early.
        if (!broken && (noise == ChEquals || noise == ChCr || noise == ChLf))
          noise = 8'h20;
        send_char(noise, broken && ($urandom_range(0, 3) == 0));
      end
      send_char(char_of_sextet($urandom_range(0, 63)), 1'b0);
    end
    case ($urandom_range(0, 3))
      0: ;
      1: repeat ($urandom_range(1, 2)) send_char(ChEquals, 1'b0);
      2: begin
        send_char(ChCr, 1'b0);
        send_char(ChLf, 1'b0);
      end
      default: send_char(ChLf, 1'b0);
    endcase
    // Characters after a stop must be ignored by the decoder.
    repeat ($urandom_range(0, 3)) send_char(CharW'($urandom_range(0, 255)), 1'b0);
  endtask

  // Covers the ends of every character range, both alphabets, each kind of
  // terminator, foreign bytes at both extremes, and restarts.
  task automatic test_directed();
    send_char("A", 1'b1);
    send_char("Z", 1'b0);
    send_char("a", 1'b0);
    send_char("z", 1'b0);
    // Foreign bytes at both ends of the byte range change nothing.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("0", 1'b0);
    send_char("9", 1'b0);
    send_char("+", 1'b0);
    send_char("-", 1'b0);
    send_char("/", 1'b0);
    send_char("_", 1'b0);
    // Equals sign stops the string with four bits still pending; they must
    // never show up, and the next character is ignored.
    send_char("=", 1'b0);
    send_char("Q", 1'b0);
    // A restart whose own character is a terminator stops the new string
    // at once.
    send_char("=", 1'b1);
    send_char("B", 1'b0);
    send_char("B", 1'b1);
    send_char(ChCr, 1'b0);
    send_char("C", 1'b0);
    send_char("C", 1'b1);
    send_char("D", 1'b0);
    send_char(ChLf, 1'b0);
    // Trailing bits of an unfinished string are dropped by the restart.
    send_char("E", 1'b1);
    send_char("F", 1'b0);
    send_char("G", 1'b1);
  endtask

  // Mostly well-formed strings with random content; one in ten picks is raw
  // noise with random start flags, and one in ten is a broken string.
  task automatic test_random_strings(input int target);
    int first;
    int len;
    int pick;
    first = items_sent;
    while (items_sent - first < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 8))
          send_char(CharW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        send_string(len, pick == 1);
      end
    end
  endtask

  // The receiver holds out_tready low for a long stretch while a string
  // keeps arriving, so the decoder's registers fill and in_tready drops.
  task automatic test_output_hold();
    send_char("Q", 1'b1);
    hold_len = PressureHold;
    hold_seq++;
    send_string(40, 1'b0);
  endtask

  // Receiver side: out_tready idles in bursts while enabled, and also serves
  // the long hold that the pressure test asks for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen  = hold_seq;
        stall_left = hold_len;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Both handshakes are sampled at the clock edge, where the values seen are
  // the ones the decoder acted on. An input transaction updates the
  // predictor; an output transaction is checked against the oldest byte.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (decode_char(in_tdata, in_tuser, predicted_byte))
          expected_bytes = {expected_bytes, predicted_byte};
      end
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("data_byte: expected nothing, actual %02h", out_tdata);
          mismatches++;
        end else begin
          oldest_byte = expected_bytes.pop_front();
          if (out_tdata !== oldest_byte) begin
            $error("data_byte: expected %02h, actual %02h", oldest_byte, out_tdata);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: a run of cycles without any transaction means the decoder or
  // the drain has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("base64_stream_decoder_core test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    // Reset is held from the start and then released for good.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    test_directed();
    test_random_strings(RandomItems);
    test_output_hold();

    // The last part runs at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_strings(FullRateItems);

    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("base64_stream_decoder_core test passed");
    end else begin
      $display("base64_stream_decoder_core test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_char_class.sv
hw/rtl/b64d_bit_packer.sv
hw/rtl/base64_stream_decoder_core.sv
dv/base64_stream_decoder_core_test.sv
